@@ rtl/bedc_pkg.sv @@
// Package for the binary edge direction classifier.
// Holds the window/result types, direction codes, position weights and
// the combinational classification function. No dependencies.
package bedc_pkg;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [3:0] DIR_NONE       = 4'd0;
  localparam logic [3:0] DIR_RIGHT      = 4'd1;
  localparam logic [3:0] DIR_RIGHT_UP   = 4'd2;
  localparam logic [3:0] DIR_UP         = 4'd3;
  localparam logic [3:0] DIR_LEFT_UP    = 4'd4;
  localparam logic [3:0] DIR_LEFT       = 4'd5;
  localparam logic [3:0] DIR_LEFT_DOWN  = 4'd6;
  localparam logic [3:0] DIR_DOWN       = 4'd7;
  localparam logic [3:0] DIR_RIGHT_DOWN = 4'd8;

  // Axial neighbors: east, north, west, south.
  localparam logic [7:0] AXIAL_MASK = 8'h55;

  // Weight per neighbor index; diagonals carry none.
  localparam logic [3:0] POS_WEIGHT [8] = '{4'd1, 4'd0, 4'd2, 4'd0,
                                            4'd4, 4'd0, 4'd7, 4'd0};

  typedef struct packed {
    logic       center_white;
    logic [7:0] neighbor_black;
  } window_t;

  typedef struct packed {
    logic [2:0] gradient;
    logic [3:0] direction;
  } result_t;

  function automatic logic [3:0] weight_to_dir(input logic [3:0] w);
    logic [3:0] d;
    case (w)
      4'd1:    d = DIR_RIGHT;
      4'd3:    d = DIR_RIGHT_UP;
      4'd2:    d = DIR_UP;
      4'd6:    d = DIR_LEFT_UP;
      4'd4:    d = DIR_LEFT;
      4'd11:   d = DIR_LEFT_DOWN;
      4'd7:    d = DIR_DOWN;
      4'd8:    d = DIR_RIGHT_DOWN;
      default: d = DIR_NONE;
    endcase
    return d;
  endfunction

  function automatic result_t classify(input window_t win);
    result_t    res;
    logic [7:0] nb;
    logic [2:0] start;
    logic [2:0] first_white;
    logic [2:0] idx;
    logic [2:0] diff;
    logic [3:0] wsum;
    logic [2:0] nblack;
    logic [1:0] restarts;
    logic       found;
    logic       seen_white;
    logic       after_white;
    nb          = win.neighbor_black;
    res         = '0;
    start       = '0;
    first_white = '0;
    wsum        = '0;
    nblack      = '0;
    restarts    = '0;
    found       = 1'b0;
    seen_white  = 1'b0;
    after_white = 1'b0;
    diff        = '0;
    for (int k = 0; k < 8; k++) begin
      idx = 3'(k);
      if (!found && nb[3'(idx + 3'd1)] && !nb[idx]) begin
        start = idx;
        found = 1'b1;
      end
    end
    for (int k = 1; k < 8; k++) begin
      idx = 3'(start + 3'(k));
      if (nb[idx]) begin
        wsum   = 4'(wsum + POS_WEIGHT[idx]);
        nblack = 3'(nblack + 3'd1);
        if (after_white) begin
          after_white = 1'b0;
          restarts    = 2'(restarts + 2'd1);
        end
      end else begin
        after_white = 1'b1;
        if (!seen_white) begin
          first_white = idx;
          seen_white  = 1'b1;
        end
      end
    end
    if (win.center_white && ((nb & AXIAL_MASK) != 8'd0) && found &&
        (restarts == 2'd0) && (nblack >= 3'd1) && (nblack <= 3'd4)) begin
      res.direction = weight_to_dir(wsum);
      diff = (start > first_white) ? 3'(start - first_white) : 3'(first_white - start);
      res.gradient = (diff > 3'd4) ? 3'(4'd8 - {1'b0, diff}) : diff;
    end
    return res;
  endfunction

endpackage

@@ rtl/binary_edge_direction_classifier.sv @@
// Top level of the binary edge direction classifier.
// Input register, classification logic from bedc_pkg, output register.
// Depends on bedc_pkg.
//
//  channel | dir | tdata bits (low first)                  | extra
//  in_     | in  | center_white[0], neighbor_black[8:1]    | -
//  out_    | out | direction[3:0], gradient[6:4]          | -
//
// One window per cycle sustained while the output is not stalled; a window
// passes the single input register, then the output register, before
// out_tvalid rises for it.
// rst_n (synchronous, active low) clears both valid flags only.
// A stalled output holds; one further window can be taken into the input
// register meanwhile, then in_tready drops.
module binary_edge_direction_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bedc_pkg::IN_TDATA_W-1:0]  in_tdata,   // center_white, neighbor_black
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bedc_pkg::OUT_TDATA_W-1:0] out_tdata   // direction, gradient, pad
);
  import bedc_pkg::*;

  window_t win_r;
  logic    win_vld_r;
  result_t res_r;
  logic    res_vld_r;
  logic    out_adv;
  logic    in_adv;
  window_t win_nxt;

  assign out_adv   = !res_vld_r || out_tready;
  assign in_adv    = !win_vld_r || out_adv;
  assign in_tready = in_adv;

  assign win_nxt.center_white   = in_tdata[0];
  assign win_nxt.neighbor_black = in_tdata[8:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_adv) begin
        win_vld_r <= in_tvalid;
      end
      if (out_adv) begin
        res_vld_r <= win_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_tvalid) begin
      win_r <= win_nxt;
    end
    if (out_adv && win_vld_r) begin
      res_r <= classify(win_r);
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {1'b0, res_r.gradient, res_r.direction};

endmodule
